[hw/rtl/ifdr_pkg.sv]
// Package for the idle frame descriptor ring.
// Item types, buffer geometry and the controller state type; no dependencies.
`default_nettype none

package ifdr_pkg;

  localparam int BUF_BYTES     = 2048;
  localparam int FRAME_MAX     = 256;
  localparam int SLOTS_DEFAULT = 16;

  localparam int OFS_W = 11;
  localparam int LEN_W = 12;
  localparam int REM_W = 9;

  localparam logic KIND_IDLE = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [REM_W-1:0] dma_remaining;
  } in_item_t;

  typedef struct packed {
    logic             frame_valid;
    logic [OFS_W-1:0] frame_start;
    logic [LEN_W-1:0] frame_length;
    logic [OFS_W-1:0] dma_start;
  } out_item_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } ctrl_state_t;

endpackage

`default_nettype wire

[hw/rtl/ifdr_slot_mem.sv]
// Descriptor slot memory: one write port, one read port, registered read data.
// Uses ifdr_pkg for the offset width.
`default_nettype none

module ifdr_slot_mem
  import ifdr_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int IDX_W = $clog2(SLOTS)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_addr,
  input  wire logic [2*OFS_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [IDX_W-1:0]   rd_addr,
  output logic      [2*OFS_W-1:0] rd_data
);

  logic [2*OFS_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/idle_frame_descriptor_ring.sv]
// An idle-line item or a pop on an empty ring gives its result in the next cycle after
// acceptance; a pop that finds a frame is read from slot memory, then registered out.
// Throughput: one item per cycle while out_ready is high, but a pop that finds a frame
// blocks the input while its slot read (S_READ) is under way.
// Reset clears control state, slot pointers, running offset, current start and out_valid;
// the slot memory is not cleared, as slots are read only once written. Uses ifdr_pkg.
`default_nettype none

module idle_frame_descriptor_ring
  import ifdr_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int IDX_W      = $clog2(SLOTS);
  localparam int ROOM_LIMIT = BUF_BYTES - FRAME_MAX;
  localparam int TOTAL      = FRAME_MAX + 1;

  ctrl_state_t state, state_next;

  logic [IDX_W-1:0] write_slot, read_slot;
  logic [OFS_W-1:0] fill_offset;
  logic [OFS_W-1:0] cur_start;

  logic               accept;
  logic               mem_rd_en;
  logic [2*OFS_W-1:0] rd_data;

  logic               len_ok;
  logic [REM_W:0]     frame_len;
  logic [OFS_W:0]     fill_sum;
  logic [OFS_W-1:0]   fill_wrap;
  logic [OFS_W-1:0]   end_ofs;
  logic               room_ok;
  logic [OFS_W-1:0]   new_start;
  logic [IDX_W-1:0]   write_slot_adv, read_slot_adv;
  logic               ring_empty;

  logic [OFS_W-1:0] rd_start, rd_end, diff;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
    logic [IDX_W:0] n;
    n = {1'b0, s} + (IDX_W+1)'(1);
    if (n >= (IDX_W+1)'(SLOTS - 1)) begin
      n = '0;
    end
    return n[IDX_W-1:0];
  endfunction

  assign accept = in_valid && in_ready;

  assign len_ok    = {1'b0, in_data.dma_remaining} < (REM_W+1)'(TOTAL);
  assign frame_len = (REM_W+1)'(TOTAL) - {1'b0, in_data.dma_remaining};
  assign fill_sum  = {1'b0, fill_offset} + (OFS_W+1)'(frame_len);
  assign fill_wrap = fill_sum[OFS_W-1:0];
  assign end_ofs   = fill_wrap - OFS_W'(1);
  assign room_ok   = {1'b0, fill_wrap} <= (OFS_W+1)'(ROOM_LIMIT);
  assign new_start = room_ok ? fill_wrap : '0;

  assign write_slot_adv = next_slot(write_slot);
  assign read_slot_adv  = next_slot(read_slot);
  assign ring_empty     = read_slot == write_slot;

  assign rd_start = rd_data[2*OFS_W-1:OFS_W];
  assign rd_end   = rd_data[OFS_W-1:0];
  assign diff     = rd_end - rd_start;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_data.kind == KIND_POP && !ring_empty) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_rd_en = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = !out_valid || out_ready;
        mem_rd_en = accept && in_data.kind == KIND_POP;
      end
      S_READ:  in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      read_slot   <= '0;
      fill_offset <= '0;
      cur_start   <= '0;
    end else begin
      if (accept && in_data.kind == KIND_IDLE && len_ok) begin
        write_slot  <= write_slot_adv;
        fill_offset <= new_start;
        cur_start   <= new_start;
      end
      if (state == S_READ) begin
        read_slot <= read_slot_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && (in_data.kind == KIND_IDLE || ring_empty)) ||
                 state == S_READ) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      out_data.frame_valid  <= 1'b1;
      out_data.frame_start  <= rd_start;
      out_data.frame_length <= {1'b0, diff} + LEN_W'(1);
      out_data.dma_start    <= cur_start;
    end else if (accept && (in_data.kind == KIND_IDLE || ring_empty)) begin
      out_data.frame_valid  <= 1'b0;
      out_data.frame_start  <= '0;
      out_data.frame_length <= '0;
      out_data.dma_start    <= (in_data.kind == KIND_IDLE && len_ok) ? new_start : cur_start;
    end
  end

  ifdr_slot_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (accept && in_data.kind == KIND_IDLE && len_ok),
    .wr_addr (write_slot),
    .wr_data ({cur_start, end_ofs}),
    .rd_en   (mem_rd_en),
    .rd_addr (read_slot),
    .rd_data (rd_data)
  );

  a_read_out_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !out_valid)
    else $error("output register busy during slot read");

  a_pop_enters_read: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.kind == KIND_POP && !ring_empty |=> state == S_READ)
    else $error("pop on non-empty ring did not start a slot read");

  a_read_gives_frame: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> out_valid && out_data.frame_valid)
    else $error("slot read did not deliver a frame item");

  a_idle_no_frame: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.kind == KIND_IDLE |=> out_valid && !out_data.frame_valid)
    else $error("idle-line item reported a frame");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, write_slot} <= (IDX_W+1)'(SLOTS - 2) &&
    {1'b0, read_slot} <= (IDX_W+1)'(SLOTS - 2))
    else $error("slot pointer beyond last used slot");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for idle_frame_descriptor_ring: drives idle-line and pop items,
// predicts each result from its own copy of the descriptor ring and compares.
// Depends on ifdr_pkg and the ring RTL.
`timescale 1ns / 100ps

module tb_top;
  import ifdr_pkg::*;

  localparam int SLOT_W      = $clog2(SLOTS_DEFAULT);
  localparam int ITEM_TARGET = 1600;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    in_item_t item;
    bit       after_drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pending_t  pending[$];
  out_item_t frames_due[$];
  int        total_items = 0;
  int        items_taken = 0;
  int        send_gap = 0;
  int        hold_cnt = 0;
  bit        long_hold_done = 1'b0;
  int        mismatches = 0;
  int        cycle_cnt = 0;
  logic      calm;

  logic [OFS_W-1:0]  ring_start [SLOTS_DEFAULT];
  logic [OFS_W-1:0]  ring_end [SLOTS_DEFAULT];
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic [OFS_W-1:0]  fill_ofs;

  idle_frame_descriptor_ring dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  assign calm = (items_taken % 512) >= 384;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s + 1 >= SLOTS_DEFAULT - 1) ? '0 : s + 1'b1;
  endfunction

  function automatic void step_ring(input in_item_t item);
    out_item_t res;
    int        len;
    res = '0;
    if (item.kind == KIND_IDLE) begin
      len = (item.dma_remaining <= FRAME_MAX + 1) ? FRAME_MAX + 1 - item.dma_remaining : 0;
      if (len > 0) begin
        fill_ofs = OFS_W'((fill_ofs + len) % BUF_BYTES);
        ring_end[wr_slot] = OFS_W'((fill_ofs + BUF_BYTES - 1) % BUF_BYTES);
        wr_slot = next_slot(wr_slot);
        if (BUF_BYTES - fill_ofs >= FRAME_MAX) begin
          ring_start[wr_slot] = fill_ofs;
        end else begin
          ring_start[wr_slot] = '0;
          fill_ofs = '0;
        end
      end
    end else if (rd_slot != wr_slot) begin
      res.frame_valid  = 1'b1;
      res.frame_start  = ring_start[rd_slot];
      res.frame_length = LEN_W'(((ring_end[rd_slot] + BUF_BYTES - ring_start[rd_slot])
                                 % BUF_BYTES) + 1);
      rd_slot = next_slot(rd_slot);
    end
    res.dma_start = ring_start[wr_slot];
    frames_due.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [REM_W-1:0] pick_remaining();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return REM_W'(FRAME_MAX + 1);
      1, 2: return REM_W'($urandom_range(FRAME_MAX + 2, (1 << REM_W) - 1));
      3: return REM_W'($urandom_range(0, 1));
      4: return REM_W'(FRAME_MAX);
      default: return REM_W'($urandom_range(0, FRAME_MAX));
    endcase
  endfunction

  task automatic add_item(input logic kind, input logic [REM_W-1:0] rem, input bit drain);
    pending_t p;
    p.item.kind          = kind;
    p.item.dma_remaining = rem;
    p.after_drain        = drain;
    pending.push_back(p);
    total_items++;
  endtask

  always @(posedge clk) begin : driver
    bit       fire;
    pending_t nxt;
    fire = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      items_taken <= 0;
      for (int i = 0; i < SLOTS_DEFAULT; i++) begin
        ring_start[i] = '0;
        ring_end[i] = '0;
      end
      wr_slot = '0;
      rd_slot = '0;
      fill_ofs = '0;
    end else begin
      if (fire) begin
        step_ring(in_data);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || fire) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending.size() > 0 &&
                     !(pending[0].after_drain && frames_due.size() != 0)) begin
          nxt = pending.pop_front();
          in_valid <= 1'b1;
          in_data <= nxt.item;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    int        r;
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: valid %0d start %0d length %0d dma_start %0d",
                     out_data.frame_valid, out_data.frame_start,
                     out_data.frame_length, out_data.dma_start);
        end else begin
          want = frames_due.pop_front();
          if (out_data.frame_valid !== want.frame_valid ||
              out_data.frame_start !== want.frame_start ||
              out_data.frame_length !== want.frame_length ||
              out_data.dma_start !== want.dma_start) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: valid %0d/%0d start %0d/%0d length %0d/%0d dma_start %0d/%0d",
                       want.frame_valid, out_data.frame_valid,
                       want.frame_start, out_data.frame_start,
                       want.frame_length, out_data.frame_length,
                       want.dma_start, out_data.dma_start);
          end
        end
      end
      r = $urandom_range(0, 99);
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else if (!long_hold_done && items_taken >= 600) begin
        out_ready <= 1'b0;
        hold_cnt <= 400;
        long_hold_done <= 1'b1;
      end else if (calm || r < 70) begin
        out_ready <= 1'b1;
      end else if (r < 97) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b0;
        hold_cnt <= $urandom_range(10, 50);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int   seg;
    int   count;
    int   pop_pct;
    bit   drain;
    bit   mid_drain;
    logic kind;

    // empty ring, zero-length and over-range remaining counts
    add_item(KIND_POP, '0, 1'b0);
    add_item(KIND_IDLE, REM_W'(FRAME_MAX + 1), 1'b0);
    add_item(KIND_IDLE, REM_W'(FRAME_MAX + 2), 1'b0);
    add_item(KIND_IDLE, REM_W'((1 << REM_W) - 1), 1'b0);
    // fill to the last start that still leaves a full frame, then cross the end
    for (int i = 0; i < 7; i++) add_item(KIND_IDLE, REM_W'(1), 1'b0);
    add_item(KIND_IDLE, '0, 1'b0);
    add_item(KIND_IDLE, REM_W'(FRAME_MAX), 1'b0);
    for (int i = 0; i < 10; i++) add_item(KIND_POP, REM_W'((1 << REM_W) - 1), 1'b0);

    drain = 1'b1;
    mid_drain = 1'b0;
    while (total_items < ITEM_TARGET) begin
      seg = $urandom_range(0, 9);
      if (seg < 6) begin
        count = $urandom_range(8, 40);
        pop_pct = (seg < 3) ? 35 : 55;
      end else if (seg < 8) begin
        count = $urandom_range(13, 17);
        pop_pct = 0;
      end else begin
        count = $urandom_range(4, 18);
        pop_pct = 100;
      end
      if (!mid_drain && total_items >= 1000) begin
        drain = 1'b1;
        mid_drain = 1'b1;
      end
      for (int i = 0; i < count; i++) begin
        kind = ($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_IDLE;
        add_item(kind, (kind == KIND_POP) ? REM_W'($urandom_range(0, (1 << REM_W) - 1))
                                          : pick_remaining(), drain);
        drain = 1'b0;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != total_items) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ifdr_pkg.sv
hw/rtl/ifdr_slot_mem.sv
hw/rtl/idle_frame_descriptor_ring.sv
bench/tb_top.sv
